@@ rtl/core/hcd_pkg.sv @@
// Shared types, codes and helper functions for the HTTP chunked decoder.
// No dependencies; imported by hcd_step and http_chunked_decoder.
package hcd_pkg;

    localparam int SIZE_WIDTH_DEF = 32;
    localparam int HEX_BITS       = 4;

    localparam logic [1:0] PH_SIZE  = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_AFTER = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [2:0] LP_LEAD   = 3'd0;
    localparam logic [2:0] LP_DIGITS = 3'd1;
    localparam logic [2:0] LP_TRAIL  = 3'd2;
    localparam logic [2:0] LP_EXT    = 3'd3;
    localparam logic [2:0] LP_BAD    = 3'd4;

    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    typedef struct packed {
        logic [1:0] phase;
        logic [2:0] line_pos;
        logic       digit_seen;
        logic       error_seen;
    } hcd_ctl_t;

    typedef struct packed {
        logic byte_valid;
        logic body_ended;
        logic malformed;
    } hcd_res_t;

    typedef struct packed {
        logic                ok;
        logic [HEX_BITS-1:0] value;
    } hcd_hex_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) ||
                   (c == 8'h0B) || (c == 8'h0C);
    endfunction

    function automatic hcd_hex_t hex_digit(input logic [7:0] c);
        hcd_hex_t r;
        r.ok    = 1'b1;
        r.value = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r.value = HEX_BITS'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r.value = HEX_BITS'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r.value = HEX_BITS'(c - 8'h57);
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/hcd_step.sv @@
// Next-state and result logic for one item of the chunked decoder.
// Depends on hcd_pkg.
module hcd_step
    import hcd_pkg::*;
#(
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
)
(
    input  logic                  mode,
    input  logic                  op,
    input  logic [7:0]            data_byte,
    input  hcd_ctl_t              ctl,
    input  logic [SIZE_WIDTH-1:0] acc,
    input  logic [SIZE_WIDTH-1:0] remaining,
    output hcd_ctl_t              ctl_next,
    output logic [SIZE_WIDTH-1:0] acc_next,
    output logic [SIZE_WIDTH-1:0] remaining_next,
    output hcd_res_t              res
);

    hcd_hex_t              hex;
    logic [SIZE_WIDTH-1:0] rem_dec;
    logic                  vld;

    assign hex     = hex_digit(data_byte);
    assign rem_dec = (remaining != '0) ? remaining - 1'b1 : '0;

    always_comb
    begin
        ctl_next       = ctl;
        acc_next       = acc;
        remaining_next = remaining;
        vld            = 1'b0;
        if (op)
        begin
            ctl_next       = '{phase: PH_SIZE, line_pos: LP_LEAD,
                               digit_seen: 1'b0, error_seen: 1'b0};
            acc_next       = '0;
            remaining_next = '0;
        end
        else if (!mode)
        begin
            vld = 1'b1;
        end
        else
        begin
            unique case (ctl.phase)
                PH_SIZE:
                begin
                    if (data_byte == CHAR_LF)
                    begin
                        if (ctl.line_pos == LP_BAD || !ctl.digit_seen)
                        begin
                            ctl_next.error_seen = 1'b1;
                            ctl_next.phase      = PH_DONE;
                        end
                        else if (acc == '0)
                        begin
                            ctl_next.phase = PH_DONE;
                        end
                        else
                        begin
                            remaining_next = acc;
                            ctl_next.phase = PH_DATA;
                        end
                        ctl_next.line_pos   = LP_LEAD;
                        ctl_next.digit_seen = 1'b0;
                        acc_next            = '0;
                    end
                    else if (ctl.line_pos == LP_BAD || ctl.line_pos == LP_EXT)
                    begin
                        ctl_next = ctl;
                    end
                    else if (data_byte == CHAR_SEMI)
                    begin
                        ctl_next.line_pos = LP_EXT;
                    end
                    else if (is_space(data_byte))
                    begin
                        if (ctl.line_pos == LP_DIGITS)
                        begin
                            ctl_next.line_pos = LP_TRAIL;
                        end
                    end
                    else if (!hex.ok || ctl.line_pos == LP_TRAIL ||
                             acc[SIZE_WIDTH-1 -: HEX_BITS] != '0)
                    begin
                        ctl_next.line_pos = LP_BAD;
                    end
                    else
                    begin
                        acc_next            = {acc[SIZE_WIDTH-HEX_BITS-1:0], hex.value};
                        ctl_next.digit_seen = 1'b1;
                        ctl_next.line_pos   = LP_DIGITS;
                    end
                end
                PH_DATA:
                begin
                    vld            = 1'b1;
                    remaining_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        ctl_next.phase = PH_AFTER;
                    end
                end
                PH_AFTER:
                begin
                    if (data_byte == CHAR_LF)
                    begin
                        ctl_next.phase = PH_SIZE;
                    end
                end
                PH_DONE:
                begin
                    ctl_next = ctl;
                end
                default:
                begin
                    ctl_next = ctl;
                end
            endcase
        end
    end

    assign res.byte_valid = vld;
    assign res.body_ended = (ctl_next.phase == PH_DONE) && !ctl_next.error_seen;
    assign res.malformed  = ctl_next.error_seen;

endmodule

@@ rtl/core/http_chunked_decoder.sv @@
// HTTP/1.1 chunked transfer decoder, top level: input register, decoder state, result register.
// Path from input accept to result valid: input register, then result register.
// Throughput: 1 item per cycle while the output is not stalled; the state update and hex shift-add are combinational.
// Reset: rst_n asynchronous, active low; clears decoder state, mode_reg and valids.
// Depends on hcd_pkg and hcd_step.
module http_chunked_decoder
    import hcd_pkg::*;
#(
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       byte_valid,
    output logic [7:0] out_byte,
    output logic       body_ended,
    output logic       malformed
);

    logic                  mode_reg;
    logic                  s0_valid_reg;
    logic                  s0_op_reg;
    logic [7:0]            s0_byte_reg;
    logic                  out_valid_reg;
    hcd_res_t              res_reg;
    logic [7:0]            out_byte_reg;
    hcd_ctl_t              ctl_reg;
    hcd_ctl_t              ctl_next;
    logic [SIZE_WIDTH-1:0] acc_reg;
    logic [SIZE_WIDTH-1:0] acc_next;
    logic [SIZE_WIDTH-1:0] rem_reg;
    logic [SIZE_WIDTH-1:0] rem_next;
    hcd_res_t              res_next;
    logic                  advance;
    logic                  in_take;
    logic                  step_en;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s0_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign step_en   = s0_valid_reg && advance;
    assign cfg_ready = 1'b1;

    hcd_step #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_step (
        .mode           (mode_reg),
        .op             (s0_op_reg),
        .data_byte      (s0_byte_reg),
        .ctl            (ctl_reg),
        .acc            (acc_reg),
        .remaining      (rem_reg),
        .ctl_next       (ctl_next),
        .acc_next       (acc_next),
        .remaining_next (rem_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctl_reg       <= '{phase: PH_SIZE, line_pos: LP_LEAD,
                               digit_seen: 1'b0, error_seen: 1'b0};
            acc_reg       <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (in_take)
            begin
                s0_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s0_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s0_valid_reg;
            end
            if (step_en)
            begin
                ctl_reg <= ctl_next;
                acc_reg <= acc_next;
                rem_reg <= rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_op_reg   <= op;
            s0_byte_reg <= data_byte;
        end
        if (step_en)
        begin
            res_reg      <= res_next;
            out_byte_reg <= res_next.byte_valid ? s0_byte_reg : 8'h00;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_valid = res_reg.byte_valid;
    assign out_byte   = out_byte_reg;
    assign body_ended = res_reg.body_ended;
    assign malformed  = res_reg.malformed;

    a_end_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(body_ended && malformed))
        else $error("body_ended and malformed both set");

    a_data_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.phase == PH_DATA |-> rem_reg != '0)
        else $error("data phase with no bytes remaining");

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.error_seen |-> ctl_reg.phase == PH_DONE)
        else $error("error seen outside done phase");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> !$past(step_en))
        else $error("result register overwritten while stalled");

endmodule

@@ bench/tb_http_chunked_decoder.sv @@
`timescale 1ns / 1ps
// Testbench for http_chunked_decoder: sends framed, broken and random chunked bodies
// and pass-through bytes under random source gaps and sink stalls, with an in-bench model.
// Depends on hcd_pkg and the decoder RTL.
module tb_http_chunked_decoder;
    import hcd_pkg::*;

    localparam logic OP_BYTE        = 1'b0;
    localparam logic OP_RESTART     = 1'b1;
    localparam logic MODE_PASS      = 1'b0;
    localparam logic MODE_CHUNKED   = 1'b1;
    localparam int   PIPE_LAT       = 2;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   ITEM_TARGET    = 1900;
    localparam int   SW             = SIZE_WIDTH_DEF;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       body_ended;
        logic       malformed;
    } chunk_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       op;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_stall;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       body_ended;
    logic       malformed;

    int src_pct      = 0;
    int sink_pct     = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;

    http_chunked_decoder uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_valid (byte_valid),
        .out_byte   (out_byte),
        .body_ended (body_ended),
        .malformed  (malformed)
    );

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
        if (v < 10)
            return 8'h30 + {4'h0, v};
        return (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(4))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0D;
            3: return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    function automatic logic [7:0] pick_not_lf();
        logic [7:0] c;
        c = 8'($urandom);
        return (c == CHAR_LF) ? 8'h00 : c;
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_pressure();
        case ($urandom_range(3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    class chunk_scoreboard;
        logic          mode;
        logic [1:0]    phase;
        logic [2:0]    line_pos;
        logic [SW-1:0] size_acc;
        logic          digit_seen;
        logic [SW-1:0] remaining;
        logic          error_seen;
        chunk_result_t expected_q[$];
        int            errors;

        function new();
            mode   = MODE_PASS;
            errors = 0;
            restart_stream();
        endfunction

        function void clear_size_line();
            line_pos   = LP_LEAD;
            size_acc   = '0;
            digit_seen = 1'b0;
        endfunction

        function void restart_stream();
            phase = PH_SIZE;
            clear_size_line();
            remaining  = '0;
            error_seen = 1'b0;
        endfunction

        function void size_line_byte(logic [7:0] c);
            int nib;
            if (c == CHAR_LF)
            begin
                if (line_pos == LP_BAD || !digit_seen)
                begin
                    error_seen = 1'b1;
                    phase      = PH_DONE;
                end
                else if (size_acc == 0)
                    phase = PH_DONE;
                else
                begin
                    remaining = size_acc;
                    phase     = PH_DATA;
                end
                clear_size_line();
            end
            else if (line_pos == LP_BAD || line_pos == LP_EXT)
                ;
            else if (c == CHAR_SEMI)
                line_pos = LP_EXT;
            else if (is_blank(c))
            begin
                if (line_pos == LP_DIGITS)
                    line_pos = LP_TRAIL;
            end
            else
            begin
                nib = hex_nibble(c);
                if (nib < 0 || line_pos == LP_TRAIL || size_acc[SW-1 -: 4] != 0)
                    line_pos = LP_BAD;
                else
                begin
                    size_acc   = {size_acc[SW-5:0], 4'(nib)};
                    digit_seen = 1'b1;
                    line_pos   = LP_DIGITS;
                end
            end
        endfunction

        function void note_item(logic o, logic [7:0] c);
            chunk_result_t r;
            logic          pass;
            r    = '0;
            pass = 1'b0;
            if (o == OP_RESTART)
            begin
                restart_stream();
                expected_q.push_back(r);
                return;
            end
            if (mode == MODE_PASS)
                pass = 1'b1;
            else
            begin
                case (phase)
                    PH_SIZE: size_line_byte(c);
                    PH_DATA:
                    begin
                        pass = 1'b1;
                        if (remaining != 0)
                            remaining = remaining - 1'b1;
                        if (remaining == 0)
                            phase = PH_AFTER;
                    end
                    PH_AFTER:
                    begin
                        if (c == CHAR_LF)
                            phase = PH_SIZE;
                    end
                    default: ;
                endcase
            end
            r.byte_valid = pass;
            r.out_byte   = pass ? c : 8'h00;
            r.body_ended = (phase == PH_DONE) && !error_seen;
            r.malformed  = error_seen;
            expected_q.push_back(r);
        endfunction

        function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(chunk_result_t got);
            chunk_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            cmp_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
            cmp_field("out_byte", want.out_byte, got.out_byte);
            cmp_field("body_ended", 8'(want.body_ended), 8'(got.body_ended));
            cmp_field("malformed", 8'(want.malformed), 8'(got.malformed));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    chunk_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        int busy_left;
        busy_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (busy_left > 0)
            begin
                out_stall <= 1'b1;
                busy_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                busy_left = pick_gap(sink_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({byte_valid, out_byte, body_ended, malformed});
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic o, input logic [7:0] c);
        int gap;
        gap = pick_gap(src_pct);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        data_byte <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(o, c);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(OP_BYTE, s[i]);
    endtask

    task automatic drain_results();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic pause_source();
        @(negedge clk);
        in_valid <= 1'b0;
        drain_results();
    endtask

    task automatic set_mode(input logic m);
        pause_source();
        repeat (PIPE_LAT + 2) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.mode = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_noise();
        int         n;
        logic [7:0] c;
        n = $urandom_range(3, 15);
        repeat (n)
        begin
            case ($urandom_range(9))
                0, 1, 2: c = CHAR_LF;
                3, 4:    c = hex_char(4'($urandom), 1'($urandom));
                5:       c = CHAR_SEMI;
                6:       c = pick_blank();
                default: c = 8'($urandom);
            endcase
            send_item(($urandom_range(15) == 0) ? OP_RESTART : OP_BYTE, c);
        end
    endtask

    task automatic send_size_line(input logic [SW-1:0] sz);
        int n;
        int k;
        bit upper;
        upper = 1'($urandom);
        repeat ($urandom_range(0, 2)) send_item(OP_BYTE, pick_blank());
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 2)) send_item(OP_BYTE, 8'h30);
        n = SW / 4;
        while (n > 1 && sz[4*n-1 -: 4] == 0)
            n--;
        for (k = n - 1; k >= 0; k--)
            send_item(OP_BYTE, hex_char(sz[4*k +: 4], upper));
        if ($urandom_range(3) == 0)
            send_item(OP_BYTE, pick_blank());
        if ($urandom_range(4) == 0)
        begin
            send_item(OP_BYTE, CHAR_SEMI);
            repeat ($urandom_range(0, 4)) send_item(OP_BYTE, pick_not_lf());
        end
        if ($urandom_range(1))
            send_item(OP_BYTE, 8'h0D);
        send_item(OP_BYTE, CHAR_LF);
    endtask

    task automatic send_payload(input int len);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(39) == 0)
            begin
                set_mode(MODE_PASS);
                repeat ($urandom_range(1, 4)) send_item(OP_BYTE, 8'($urandom));
                set_mode(MODE_CHUNKED);
            end
            send_item(OP_BYTE, 8'($urandom));
        end
    endtask

    task automatic send_stream();
        int         nchunks;
        int         len;
        int         k;
        bit         upper;
        logic [7:0] c;
        upper = 1'($urandom);
        send_item(OP_RESTART, 8'($urandom));
        nchunks = $urandom_range(0, 4);
        for (k = 0; k < nchunks; k++)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            send_size_line(SW'(len));
            send_payload(len);
            repeat ($urandom_range(0, 2)) send_item(OP_BYTE, pick_not_lf());
            if ($urandom_range(1))
                send_item(OP_BYTE, 8'h0D);
            send_item(OP_BYTE, CHAR_LF);
        end
        case ($urandom_range(9))
            0:
            begin
                if ($urandom_range(1))
                    send_item(OP_BYTE, hex_char(4'($urandom), upper));
                do
                    c = 8'($urandom);
                while (hex_nibble(c) >= 0 || is_blank(c) || c == CHAR_SEMI || c == CHAR_LF);
                send_item(OP_BYTE, c);
                send_item(OP_BYTE, CHAR_LF);
            end
            1:
            begin
                if ($urandom_range(1))
                    send_item(OP_BYTE, pick_blank());
                if ($urandom_range(1))
                begin
                    send_item(OP_BYTE, CHAR_SEMI);
                    send_item(OP_BYTE, hex_char(4'($urandom), upper));
                end
                send_item(OP_BYTE, CHAR_LF);
            end
            2:
            begin
                send_item(OP_BYTE, hex_char(4'($urandom), upper));
                send_item(OP_BYTE, pick_blank());
                send_item(OP_BYTE, hex_char(4'($urandom), upper));
                send_item(OP_BYTE, CHAR_LF);
            end
            3:
            begin
                send_item(OP_BYTE, hex_char(4'($urandom_range(1, 15)), upper));
                repeat ($urandom_range(8, 10))
                    send_item(OP_BYTE, hex_char(4'($urandom), upper));
                send_item(OP_BYTE, CHAR_LF);
            end
            4:
            begin
                if ($urandom_range(1))
                    send_text("0x");
                else
                    send_text("+");
                send_item(OP_BYTE, hex_char(4'($urandom), upper));
                send_item(OP_BYTE, CHAR_LF);
            end
            5:
            begin
                send_size_line($urandom_range(1) ? {SW{1'b1}} : SW'($urandom));
                send_payload($urandom_range(1, 5));
            end
            default: send_size_line('0);
        endcase
        repeat ($urandom_range(0, 3)) send_item(OP_BYTE, 8'($urandom));
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = OP_BYTE;
        data_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_data  = MODE_PASS;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, CHAR_LF);
        send_item(OP_RESTART, 8'h5A);
        set_mode(MODE_CHUNKED);
        send_item(OP_RESTART, 8'hA5);
        send_text(" 2;e\n");
        send_text("ab\r\n");
        send_text("0\n");
        send_text("z");
        send_item(OP_RESTART, 8'h00);
        send_text("-\n");
        send_item(OP_RESTART, 8'hFF);
        send_text("1 1\n");
        send_item(OP_RESTART, 8'h00);
        send_text(";\n");

        while (items_sent < ITEM_TARGET)
        begin
            src_pct  = pick_pressure();
            sink_pct = pick_pressure();
            case ($urandom_range(19))
                0, 1, 2:
                    send_noise();
                3, 4:
                begin
                    set_mode(MODE_PASS);
                    send_noise();
                    set_mode(MODE_CHUNKED);
                end
                5:
                    pause_source();
                default:
                    send_stream();
            endcase
        end

        pause_source();
        repeat (PIPE_LAT + 4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/hcd_pkg.sv
rtl/core/hcd_step.sv
rtl/core/http_chunked_decoder.sv
bench/tb_http_chunked_decoder.sv
